### src/bsc_pkg.sv
// Shared types and constants for the bond sphere cover block.
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int MAX_SPHERES_DEF     = 64;
  localparam int MAX_CORRECTIONS_DEF = 5;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 33;
  localparam int LEN_W   = 33;
  localparam int SUM_W   = 66;
  localparam int VOL_W   = 70;
  localparam int A_W     = 70;
  localparam int B_W     = 34;
  localparam int RES_W   = 104;
  localparam int REM_W   = 34;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;

  // pi in Q2.30, rounded to nearest
  localparam logic [31:0] PI_Q = 32'hC90FDAA2;

  typedef enum logic [2:0] {
    ALU_MUL  = 3'b001,
    ALU_DIV  = 3'b010,
    ALU_SQRT = 3'b100
  } alu_op_t;

  typedef struct packed {
    logic           start;
    alu_op_t        op;
    logic [A_W-1:0] a;
    logic [B_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] res;
    logic [REM_W-1:0] rem;
  } alu_rsp_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] start;
    logic [2:0]              neg;
    logic [2:0][MAG_W-1:0]   q0;
    logic [2:0][LEN_W-1:0]   r0;
    logic [2:0][MAG_W-1:0]   qs;
    logic [2:0][LEN_W-1:0]   rs;
    logic [LEN_W-1:0]        dlen;
    logic [LEN_W-1:0]        radius;
    logic [CNT_W-1:0]        count;
    logic                    sat;
  } emit_load_t;

endpackage

### src/bsc_alu.sv
// Shared radix-2 unit: multiply, divide and square root, one bit per cycle.
`timescale 1ns / 1ps
module bsc_alu import bsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_cmd_t cmd,
  output alu_rsp_t rsp
);

  localparam int DIV_STEPS  = B_W;
  localparam int SQRT_STEPS = SUM_W / 2;

  alu_op_t          op_q;
  logic             busy;
  logic             done;
  logic [5:0]       cnt;
  logic [RES_W-1:0] acc;
  logic [RES_W-1:0] ash;
  logic [B_W-1:0]   bsh;
  logic [36:0]      rem;
  logic [33:0]      root;
  logic [A_W-1:0]   nsh;
  logic [B_W-1:0]   den;

  logic [36:0] div_t;
  logic        div_ge;
  logic [36:0] sq_t;
  logic [36:0] sq_trial;
  logic        sq_ge;

  always_comb begin
    div_t    = {rem[35:0], nsh[A_W-1]};
    div_ge   = div_t >= {3'b0, den};
    sq_t     = {rem[34:0], nsh[A_W-1:A_W-2]};
    sq_trial = {1'b0, root, 2'b01};
    sq_ge    = sq_t >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op_q <= cmd.op;
        unique case (cmd.op)
          ALU_MUL: begin
            acc <= '0;
            ash <= {34'b0, cmd.a};
            bsh <= cmd.b;
          end
          ALU_DIV: begin
            acc <= '0;
            rem <= {3'b0, cmd.a[67:34]};
            nsh <= {cmd.a[33:0], 36'b0};
            den <= cmd.b;
            cnt <= 6'(DIV_STEPS);
          end
          ALU_SQRT: begin
            root <= '0;
            rem  <= '0;
            nsh  <= {cmd.a[SUM_W-1:0], 4'b0};
            cnt  <= 6'(SQRT_STEPS);
          end
          default: ;
        endcase
      end else if (busy) begin
        unique case (op_q)
          ALU_MUL: begin
            if (bsh == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (bsh[0]) acc <= acc + ash;
              ash <= {ash[RES_W-2:0], 1'b0};
              bsh <= {1'b0, bsh[B_W-1:1]};
            end
          end
          ALU_DIV: begin
            rem <= div_ge ? div_t - {3'b0, den} : div_t;
            acc <= {acc[RES_W-2:0], div_ge};
            nsh <= {nsh[A_W-2:0], 1'b0};
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          ALU_SQRT: begin
            rem  <= sq_ge ? sq_t - sq_trial : sq_t;
            root <= {root[32:0], sq_ge};
            nsh  <= {nsh[A_W-3:0], 2'b0};
            cnt  <= cnt - 6'd1;
            if (cnt == 6'd1) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.res  = (op_q == ALU_SQRT) ? {70'b0, root} : acc;
    rsp.rem  = rem[REM_W-1:0];
  end

endmodule

### src/bsc_emit.sv
// Sphere emitter: steps the center offsets by exact quotient/remainder adds, one beat per sphere.
`timescale 1ns / 1ps
module bsc_emit import bsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  emit_load_t                ld,
  output logic                      sphere_valid,
  input  logic                      sphere_stall,
  output logic [IDX_W-1:0]          sphere_index,
  output logic signed [COORD_W-1:0] center_x,
  output logic signed [COORD_W-1:0] center_y,
  output logic signed [COORD_W-1:0] center_z,
  output logic [LEN_W-1:0]          radius,
  output logic [CNT_W-1:0]          sphere_count,
  output logic                      saturated,
  output logic                      last,
  output logic                      done
);

  logic                    valid;
  logic [IDX_W-1:0]        idx;
  logic [2:0][MAG_W-1:0]   off;
  logic [2:0][LEN_W-1:0]   rm;
  logic [2:0][COORD_W-1:0] st;
  logic [2:0]              neg;
  logic [2:0][MAG_W-1:0]   qs;
  logic [2:0][LEN_W-1:0]   rs;
  logic [LEN_W-1:0]        dlen;
  logic [LEN_W-1:0]        rad;
  logic [CNT_W-1:0]        count;
  logic                    sat;

  logic [2:0][MAG_W-1:0]   off_next;
  logic [2:0][LEN_W-1:0]   rm_next;
  logic [2:0][COORD_W-1:0] ctr;
  logic [LEN_W:0]          rsum;
  logic                    wrap;
  logic                    is_last;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rsum        = {1'b0, rm[a]} + {1'b0, rs[a]};
      wrap        = (dlen != '0) && (rsum >= {1'b0, dlen});
      rm_next[a]  = wrap ? LEN_W'(rsum - {1'b0, dlen}) : rsum[LEN_W-1:0];
      off_next[a] = off[a] + qs[a] + MAG_W'(wrap);
      ctr[a]      = neg[a] ? st[a] - off[a][COORD_W-1:0] : st[a] + off[a][COORD_W-1:0];
    end
    is_last = ({1'b0, idx} + 7'd1) == count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
      off   <= ld.q0;
      rm    <= ld.r0;
      st    <= ld.start;
      neg   <= ld.neg;
      qs    <= ld.qs;
      rs    <= ld.rs;
      dlen  <= ld.dlen;
      rad   <= ld.radius;
      count <= ld.count;
      sat   <= ld.sat;
    end else if (valid && !sphere_stall) begin
      // advance to the next sphere, or drop valid after the last beat
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 6'd1;
        off <= off_next;
        rm  <= rm_next;
      end
    end
  end

  always_comb begin
    sphere_valid = valid;
    sphere_index = idx;
    center_x     = ctr[0];
    center_y     = ctr[1];
    center_z     = ctr[2];
    radius       = rad;
    sphere_count = count;
    saturated    = sat;
    last         = is_last;
    done         = valid && !sphere_stall && is_last;
  end

endmodule

### src/bond_sphere_cover.sv
// The delay from an accepted item to its first sphere beat is set by the shared radix-2 unit
// (a multiply runs over the multiplier's bits, a divide and the square root produce one result
// bit per step) and by the count search, which tests one candidate count per cycle
// (up to MAX_SPHERES+MAX_CORRECTIONS+2), plus up to five correction rounds.
// One item at a time; after the first beat, one sphere beat per cycle while sphere_stall is low,
// and the next item is taken only after the last beat. Reset is synchronous and active high:
// it clears the sequencer, the shared unit's control and the emitter's valid.
`timescale 1ns / 1ps
module bond_sphere_cover import bsc_pkg::*; #(
  parameter int MAX_SPHERES     = MAX_SPHERES_DEF,
  parameter int MAX_CORRECTIONS = MAX_CORRECTIONS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] start_z,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic signed [COORD_W-1:0] end_z,
  input  logic [31:0]               target_volume,
  output logic                      sphere_valid,
  input  logic                      sphere_stall,
  output logic [IDX_W-1:0]          sphere_index,
  output logic signed [COORD_W-1:0] center_x,
  output logic signed [COORD_W-1:0] center_y,
  output logic signed [COORD_W-1:0] center_z,
  output logic [LEN_W-1:0]          radius,
  output logic [CNT_W-1:0]          sphere_count,
  output logic                      saturated,
  output logic                      last
);

  localparam int START_CAP = MAX_SPHERES + MAX_CORRECTIONS + 2;
  localparam int STEP_W    = $clog2(MAX_CORRECTIONS + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(START_CAP);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_SPHERES);

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_MAG  = 20'h00002,
    ST_ROOT = 20'h00004,
    ST_D2   = 20'h00008,
    ST_D3   = 20'h00010,
    ST_W    = 20'h00020,
    ST_SRCH = 20'h00040,
    ST_CSQ  = 20'h00080,
    ST_C6   = 20'h00100,
    ST_NSQ  = 20'h00200,
    ST_CN   = 20'h00400,
    ST_LHS  = 20'h00800,
    ST_RHS  = 20'h01000,
    ST_CSAT = 20'h02000,
    ST_RAD  = 20'h04000,
    ST_RM   = 20'h08000,
    ST_Q0   = 20'h10000,
    ST_QS   = 20'h20000,
    ST_LOAD = 20'h40000,
    ST_EMIT = 20'h80000
  } state_t;

  state_t                  state;
  logic                    launched;
  logic [1:0]              ax;
  logic [2:0][COORD_W-1:0] start_r;
  logic [2:0]              neg;
  logic [2:0][MAG_W-1:0]   mag;
  logic [31:0]             vol;
  logic [SUM_W-1:0]        sum;
  logic [LEN_W-1:0]        dlen;
  logic [VOL_W-1:0]        wv;
  logic [RES_W-1:0]        aux;
  logic [49:0]             ssum;
  logic [43:0]             tstep;
  logic [CNT_W-1:0]        c;
  logic                    moved;
  logic                    sat;
  logic [STEP_W-1:0]       step;
  logic [13:0]             csq;
  logic [13:0]             nsq;
  logic [LEN_W-1:0]        rad;
  logic [2:0][MAG_W-1:0]   q0;
  logic [2:0][LEN_W-1:0]   r0;
  logic [2:0][MAG_W-1:0]   qs;
  logic [2:0][LEN_W-1:0]   rs;

  logic [2:0][COORD_W-1:0] s_in;
  logic [2:0][COORD_W-1:0] e_in;
  logic [2:0][MAG_W-1:0]   dx;
  logic [2:0][MAG_W-1:0]   mag_in;
  logic [35:0]             twelve_v;
  logic [43:0]             six_v;
  logic [16:0]             six_csq;
  logic [14:0]             csq_nsq;
  logic [CNT_W-1:0]        c_inc;

  alu_cmd_t   cmd;
  alu_rsp_t   rsp;
  emit_load_t ld;
  logic       emit_load;
  logic       emit_done;
  logic       accept;

  always_comb begin
    s_in = {start_z, start_y, start_x};
    e_in = {end_z, end_y, end_x};
    for (int a = 0; a < 3; a++) begin
      dx[a]     = {e_in[a][COORD_W-1], e_in[a]} - {s_in[a][COORD_W-1], s_in[a]};
      mag_in[a] = dx[a][MAG_W-1] ? (~dx[a] + 33'd1) : dx[a];
    end
    twelve_v = {1'b0, vol, 3'b0} + {2'b0, vol, 2'b0};
    six_v    = {10'b0, vol, 2'b0} + {11'b0, vol, 1'b0};
    six_csq  = {1'b0, csq, 2'b0} + {2'b0, csq, 1'b0};
    csq_nsq  = {1'b0, csq} + {1'b0, nsq};
    c_inc    = c + 7'd1;
    item_stall = (state != ST_IDLE);
    accept     = item_valid && (state == ST_IDLE);
    emit_load  = (state == ST_LOAD);
  end

  // shared unit command for the current step
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = ALU_MUL;
    cmd.a     = '0;
    cmd.b     = '0;
    unique case (state)
      ST_MAG: begin
        cmd.a = {37'b0, mag[ax]};
        cmd.b = {1'b0, mag[ax]};
      end
      ST_ROOT: begin
        cmd.op = ALU_SQRT;
        cmd.a  = {4'b0, sum};
      end
      ST_D2: begin
        cmd.a = {37'b0, dlen};
        cmd.b = {1'b0, dlen};
      end
      ST_D3: begin
        cmd.a = aux[A_W-1:0];
        cmd.b = {1'b0, dlen};
      end
      ST_W: begin
        cmd.a = aux[101:32];
        cmd.b = {2'b0, PI_Q};
      end
      ST_CSQ: begin
        cmd.a = {63'b0, c};
        cmd.b = {27'b0, c};
      end
      ST_C6: begin
        cmd.a = {38'b0, vol};
        cmd.b = {17'b0, six_csq};
      end
      ST_NSQ: begin
        cmd.a = {63'b0, c_inc};
        cmd.b = {27'b0, c_inc};
      end
      ST_CN: begin
        cmd.a = {56'b0, csq};
        cmd.b = {20'b0, nsq};
      end
      ST_LHS: begin
        cmd.a = {34'b0, twelve_v};
        cmd.b = aux[B_W-1:0];
      end
      ST_RHS: begin
        cmd.a = wv;
        cmd.b = {19'b0, csq_nsq};
      end
      ST_RAD: begin
        cmd.op = ALU_DIV;
        cmd.a  = {37'b0, dlen};
        cmd.b  = {26'b0, c, 1'b0};
      end
      ST_RM: begin
        cmd.a = {37'b0, mag[ax]};
        cmd.b = {1'b0, rad};
      end
      ST_Q0: begin
        cmd.op = ALU_DIV;
        cmd.a  = aux[A_W-1:0];
        cmd.b  = {1'b0, dlen};
      end
      ST_QS: begin
        cmd.op = ALU_DIV;
        cmd.a  = {aux[A_W-2:0], 1'b0};
        cmd.b  = {1'b0, dlen};
      end
      default: ;
    endcase
    unique case (state)
      ST_MAG, ST_ROOT, ST_D2, ST_D3, ST_W, ST_CSQ, ST_C6, ST_NSQ, ST_CN, ST_LHS, ST_RHS,
      ST_RM, ST_Q0, ST_QS: cmd.start = !launched;
      ST_RAD:              cmd.start = !launched && (dlen != '0);
      default:             cmd.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      if (cmd.start) launched <= 1'b1;
      if (rsp.done)  launched <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            start_r <= s_in;
            for (int a = 0; a < 3; a++) neg[a] <= dx[a][MAG_W-1];
            mag   <= mag_in;
            vol   <= target_volume;
            sum   <= '0;
            ax    <= '0;
            sat   <= 1'b0;
            state <= ST_MAG;
          end
        end
        ST_MAG: begin
          if (rsp.done) begin
            sum <= sum + rsp.res[SUM_W-1:0];
            if (ax == 2'd2) begin
              ax    <= '0;
              state <= ST_ROOT;
            end else begin
              ax <= ax + 2'd1;
            end
          end
        end
        ST_ROOT: begin
          if (rsp.done) begin
            dlen  <= rsp.res[LEN_W-1:0];
            state <= ST_D2;
          end
        end
        ST_D2: begin
          if (rsp.done) begin
            aux   <= rsp.res;
            state <= ST_D3;
          end
        end
        ST_D3: begin
          if (rsp.done) begin
            aux   <= rsp.res;
            state <= ST_W;
          end
        end
        ST_W: begin
          if (rsp.done) begin
            wv <= rsp.res[99:30];
            if (vol == '0) begin
              c     <= MAX_C;
              sat   <= 1'b1;
              state <= ST_RAD;
            end else begin
              ssum  <= '0;
              tstep <= six_v;
              c     <= '0;
              state <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          // c holds the candidate k; 6k^2V advances by 6V(2k+1)
          if ((c < CAP_C) && ({20'b0, ssum} < wv)) begin
            ssum  <= ssum + {6'b0, tstep};
            tstep <= tstep + {8'b0, twelve_v};
            c     <= c_inc;
          end else begin
            c     <= (c == CAP_C) ? CAP_C : c_inc;
            moved <= 1'b0;
            step  <= '0;
            state <= ST_CSQ;
          end
        end
        ST_CSQ: begin
          if (rsp.done) begin
            csq   <= rsp.res[13:0];
            state <= ST_C6;
          end
        end
        ST_C6: begin
          if (rsp.done) begin
            if (wv > rsp.res[VOL_W-1:0]) begin
              if (!moved) begin
                c     <= c_inc;
                state <= ST_CSAT;
              end else begin
                state <= ST_NSQ;
              end
            end else if (c == 7'd1) begin
              state <= ST_CSAT;
            end else begin
              c     <= c - 7'd1;
              moved <= 1'b1;
              step  <= step + 1'b1;
              state <= (step == STEP_W'(MAX_CORRECTIONS - 1)) ? ST_CSAT : ST_CSQ;
            end
          end
        end
        ST_NSQ: begin
          if (rsp.done) begin
            nsq   <= rsp.res[13:0];
            state <= ST_CN;
          end
        end
        ST_CN: begin
          if (rsp.done) begin
            aux   <= rsp.res;
            state <= ST_LHS;
          end
        end
        ST_LHS: begin
          if (rsp.done) begin
            aux   <= rsp.res;
            state <= ST_RHS;
          end
        end
        ST_RHS: begin
          if (rsp.done) begin
            // step up when c+1 lies strictly nearer the target
            if (aux < rsp.res) c <= c_inc;
            state <= ST_CSAT;
          end
        end
        ST_CSAT: begin
          if (c > MAX_C) begin
            c   <= MAX_C;
            sat <= 1'b1;
          end
          state <= ST_RAD;
        end
        ST_RAD: begin
          if (dlen == '0) begin
            rad   <= '0;
            q0    <= '0;
            r0    <= '0;
            qs    <= '0;
            rs    <= '0;
            state <= ST_LOAD;
          end else if (rsp.done) begin
            rad   <= rsp.res[LEN_W-1:0];
            ax    <= '0;
            state <= ST_RM;
          end
        end
        ST_RM: begin
          if (rsp.done) begin
            aux   <= rsp.res;
            state <= ST_Q0;
          end
        end
        ST_Q0: begin
          if (rsp.done) begin
            q0[ax] <= rsp.res[MAG_W-1:0];
            r0[ax] <= rsp.rem[LEN_W-1:0];
            state  <= ST_QS;
          end
        end
        ST_QS: begin
          if (rsp.done) begin
            qs[ax] <= rsp.res[MAG_W-1:0];
            rs[ax] <= rsp.rem[LEN_W-1:0];
            if (ax == 2'd2) begin
              state <= ST_LOAD;
            end else begin
              ax    <= ax + 2'd1;
              state <= ST_RM;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ld.start  = start_r;
    ld.neg    = neg;
    ld.q0     = q0;
    ld.r0     = r0;
    ld.qs     = qs;
    ld.rs     = rs;
    ld.dlen   = dlen;
    ld.radius = rad;
    ld.count  = c;
    ld.sat    = sat;
  end

  bsc_alu u_alu (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  bsc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (emit_load),
    .ld           (ld),
    .sphere_valid (sphere_valid),
    .sphere_stall (sphere_stall),
    .sphere_index (sphere_index),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .radius       (radius),
    .sphere_count (sphere_count),
    .saturated    (saturated),
    .last         (last),
    .done         (emit_done)
  );

endmodule

### bench/tb_bond_sphere_cover.sv
// Testbench for bond_sphere_cover: random handshakes checked against a bit-exact sphere planner.
`timescale 1ns / 1ps

typedef struct {
  logic [5:0]  idx;
  logic [31:0] cx, cy, cz;
  logic [32:0] rad;
  logic [6:0]  cnt;
  logic        sat;
  logic        lst;
} sphere_beat_t;

class cover_scoreboard;
  localparam int SPHERE_LIMIT = 64;
  localparam int STEP_LIMIT   = 5;
  localparam int START_LIMIT  = SPHERE_LIMIT + STEP_LIMIT + 2;
  localparam logic [127:0] PI_Q30 = 128'hC90FDAA2;

  sphere_beat_t expected_spheres[$];
  int errors;
  int spheres_seen;
  int saturated_items;
  int max_count;

  function logic [63:0] isqrt(logic [127:0] s);
    logic [63:0] res, t;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      t = res | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= s) res = t;
    end
    return res;
  endfunction

  // Plan the spheres of one segment and queue one beat per sphere.
  function void plan_spheres(logic [31:0] sp[3], logic [31:0] ep[3], logic [31:0] vol);
    logic signed [33:0] delta[3];
    logic [127:0] mag[3];
    logic [127:0] sum, dlen, w, v, k, c, n, r, off, lhs, rhs;
    logic [31:0] ctr[3];
    logic sat, moved;
    sphere_beat_t beat;
    sum = '0;
    for (int a = 0; a < 3; a++) begin
      delta[a] = $signed({{2{ep[a][31]}}, ep[a]}) - $signed({{2{sp[a][31]}}, sp[a]});
      mag[a] = delta[a] < 0 ? 128'(-delta[a]) : 128'(delta[a]);
      sum = sum + mag[a] * mag[a];
    end
    dlen = 128'(isqrt(sum));
    w = (((dlen * dlen * dlen) >> 32) * PI_Q30) >> 30;
    v = 128'(vol);
    sat = 1'b0;
    if (vol == 0) begin
      c = SPHERE_LIMIT;
      sat = 1'b1;
    end else begin
      k = 0;
      moved = 1'b0;
      while (k < START_LIMIT && 6 * k * k * v < w) k++;
      c = (k + 1 > START_LIMIT) ? START_LIMIT : k + 1;
      for (int s = 0; s < STEP_LIMIT; s++) begin
        if (w > 6 * c * c * v) begin
          n = c + 1;
          lhs = 12 * v * c * c * n * n;
          rhs = w * (c * c + n * n);
          if (!moved || lhs < rhs) c++;
          break;
        end
        if (c == 1) break;
        c--;
        moved = 1'b1;
      end
      if (c > SPHERE_LIMIT) begin
        c = SPHERE_LIMIT;
        sat = 1'b1;
      end
    end
    r = dlen / (2 * c);
    if (sat) saturated_items++;
    if (int'(c) > max_count) max_count = int'(c);
    for (int i = 0; i < int'(c); i++) begin
      for (int a = 0; a < 3; a++) begin
        off = (dlen != 0) ? ((128'(2 * i + 1) * r) * mag[a]) / dlen : '0;
        ctr[a] = delta[a] < 0 ? sp[a] - off[31:0] : sp[a] + off[31:0];
      end
      beat.idx = i[5:0];
      beat.cx  = ctr[0];
      beat.cy  = ctr[1];
      beat.cz  = ctr[2];
      beat.rad = r[32:0];
      beat.cnt = c[6:0];
      beat.sat = sat;
      beat.lst = (i + 1 == int'(c));
      expected_spheres = {expected_spheres, beat};
    end
  endfunction

  function void compare(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", field, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_sphere(sphere_beat_t got);
    sphere_beat_t exp_b;
    spheres_seen++;
    if (expected_spheres.size() == 0) begin
      $error("unexpected sphere beat, index %0d", got.idx);
      errors++;
      return;
    end
    exp_b = expected_spheres.pop_front();
    compare("sphere_index", exp_b.idx, got.idx);
    compare("center_x", exp_b.cx, got.cx);
    compare("center_y", exp_b.cy, got.cy);
    compare("center_z", exp_b.cz, got.cz);
    compare("radius", exp_b.rad, got.rad);
    compare("sphere_count", exp_b.cnt, got.cnt);
    compare("saturated", exp_b.sat, got.sat);
    compare("last", exp_b.lst, got.lst);
  endfunction
endclass

module tb_bond_sphere_cover;
  import bsc_pkg::*;

  localparam int RANDOM_ITEMS = 290;
  localparam int CYCLE_LIMIT  = 4_000_000;

  logic clk, rst;
  logic item_valid, item_stall;
  logic signed [COORD_W-1:0] start_x, start_y, start_z, end_x, end_y, end_z;
  logic [31:0] target_volume;
  logic sphere_valid, sphere_stall;
  logic [IDX_W-1:0] sphere_index;
  logic signed [COORD_W-1:0] center_x, center_y, center_z;
  logic [LEN_W-1:0] radius;
  logic [CNT_W-1:0] sphere_count;
  logic saturated, last;

  cover_scoreboard sb;
  int cycles;
  int items_sent;
  bit calm;
  bit draining;

  bond_sphere_cover dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_bond_sphere_cover failed");
      $finish;
    end
    if (!rst && sphere_valid && !sphere_stall)
      sb.check_sphere('{sphere_index, center_x, center_y, center_z, radius,
                        sphere_count, saturated, last});
  end

  // Stall the sphere side for a random number of cycles per beat.
  initial begin
    int n;
    sphere_stall = 1'b0;
    @(negedge rst);
    forever begin
      n = (calm || draining) ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        @(negedge clk);
        sphere_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        sphere_stall = 1'b0;
      end
      do @(posedge clk); while (!(sphere_valid && !sphere_stall));
    end
  end

  task automatic send_segment(logic [31:0] sp[3], logic [31:0] ep[3], logic [31:0] vol);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    {start_x, start_y, start_z} = {sp[0], sp[1], sp[2]};
    {end_x, end_y, end_z} = {ep[0], ep[1], ep[2]};
    target_volume = vol;
    item_valid = 1'b1;
    do @(posedge clk); while (!(item_valid && !item_stall));
    sb.plan_spheres(sp, ep, vol);
    items_sent++;
  endtask

  task automatic send_random();
    logic [31:0] sp[3], ep[3], vol;
    logic signed [31:0] d;
    int shape;
    shape = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      sp[a] = $urandom;
      d = $signed($urandom) >>> $urandom_range(0, 31);
      ep[a] = (shape == 0) ? $urandom : sp[a] + d;
    end
    vol = ($urandom_range(0, 29) == 0) ? 32'd0 : $urandom >> $urandom_range(0, 31);
    send_segment(sp, ep, vol);
  endtask

  initial begin
    logic [31:0] lo[3], hi[3], org[3], unit[3], neg[3];
    sb = new();
    cycles = 0;
    items_sent = 0;
    calm = 1'b0;
    draining = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    {start_x, start_y, start_z, end_x, end_y, end_z} = '0;
    target_volume = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    org = '{32'd0, 32'd0, 32'd0};
    unit = '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000};
    neg = '{32'hFFF0_0000, 32'h0008_0000, 32'hFFFF_8000};
    // zero length, zero volume, huge and tiny volumes, full-range diagonals
    send_segment(org, org, 32'h0001_0000);
    send_segment(hi, hi, 32'd0);
    send_segment(org, unit, 32'd0);
    send_segment(org, unit, 32'hFFFF_FFFF);
    send_segment(org, unit, 32'd1);
    send_segment(org, unit, 32'h0000_8000);
    send_segment(lo, hi, 32'hFFFF_FFFF);
    send_segment(hi, lo, 32'h0000_0001);
    send_segment(lo, hi, 32'd0);
    send_segment(hi, lo, 32'h8000_0000);
    send_segment(org, neg, 32'h0010_0000);
    send_segment(neg, org, 32'h0000_0400);
    send_segment(neg, hi, 32'h1000_0000);
    send_segment(lo, neg, 32'h0001_0000);
    send_segment(unit, lo, 32'h00FF_FFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i / 40) % 3) == 2;
      send_random();
    end
    @(negedge clk);
    item_valid = 1'b0;
    draining = 1'b1;

    while (sb.expected_spheres.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("%0d segments sent, %0d sphere beats checked, %0d saturated, largest count %0d",
             items_sent, sb.spheres_seen, sb.saturated_items, sb.max_count);
    if (sb.errors == 0 && sb.expected_spheres.size() == 0) begin
      $display("tb_bond_sphere_cover passed");
    end else begin
      $display("tb_bond_sphere_cover failed");
    end
    $finish;
  end
endmodule
